FILE: sv/sprc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sprc_pkg
// Shared types and constants for the session pool with refcount and eviction.
// ----------------------------------------------------------------------------
package sprc_pkg;

	localparam int SLOTS     = 16;
	localparam int SLOT_W    = 4;
	localparam int KEY_W     = 32;
	localparam int TIME_W    = 48;

	// operations
	localparam logic [1:0] OP_ACQUIRE    = 2'd0;
	localparam logic [1:0] OP_RELEASE    = 2'd1;
	localparam logic [1:0] OP_INVALIDATE = 2'd2;
	localparam logic [1:0] OP_KEEPALIVE  = 2'd3;

	// status codes
	localparam logic [2:0] ST_REUSED    = 3'd0;
	localparam logic [2:0] ST_CREATED   = 3'd1;
	localparam logic [2:0] ST_CONN_FAIL = 3'd2;
	localparam logic [2:0] ST_FULL      = 3'd3;
	localparam logic [2:0] ST_NOT_LIVE  = 3'd4;
	localparam logic [2:0] ST_UNDERFLOW = 3'd5;
	localparam logic [2:0] ST_DONE      = 3'd6;

	// configuration register indexes
	localparam logic [1:0] CFG_IDLE_TIMEOUT = 2'd0;
	localparam logic [1:0] CFG_MAX_ENTRIES  = 2'd1;
	localparam logic [1:0] CFG_MAX_MISSED   = 2'd2;

	localparam logic [47:0] IDLE_TIMEOUT_RST = 48'd60000000;
	localparam logic [4:0]  MAX_ENTRIES_RST  = 5'd8;
	localparam logic [3:0]  MAX_MISSED_RST   = 4'd3;

	typedef logic [SLOT_W-1:0] slot_t;

endpackage
`default_nettype wire

FILE: sv/session_pool_refcount_evict.sv
`default_nettype none
// ----------------------------------------------------------------------------
// session_pool_refcount_evict
// Sixteen-entry refcounted session table with idle reaping and LRU trimming.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive the item fields and pulse start while busy is low.
//   The item is taken at that edge; busy is high from the next cycle and
//   stays high until the cycle in which the result is shown. Done is high for
//   one cycle; the result ports hold the result. The receiver cannot stall it.
//   Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; ready is
//   high whenever the block is idle.
//   Sequencing: one shared slot walker visits one slot a cycle. A key search,
//   allocation, the idle reap pass with the count pass folded into it, and
//   each LRU trim scan walk the slots in turn (at most 16 trims). An acquire
//   hit goes from the search to the finish step; a create runs the search,
//   allocation, reap pass and any trims; a slot operation without reaping
//   goes from the slot step to the finish step.
//   Throughput: one item at a time; the next item may start in the cycle that
//   done is high.
//   Reset: all entries invalid, registers at their reset values, no clearing
//   pass is needed.
// ----------------------------------------------------------------------------
module session_pool_refcount_evict (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  operation,
	input  wire logic [31:0] lookup_key,
	input  wire logic [3:0]  slot_index,
	input  wire logic [47:0] now_time,
	input  wire logic        connect_ok,
	input  wire logic        echo_ok,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [47:0] cfg_data,
	output logic             done,
	output logic [2:0]       status,
	output logic [3:0]       result_slot,
	output logic [7:0]       ref_count,
	output logic             entry_removed,
	output logic [4:0]       evicted_count
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SEARCH = 3'd1;
	localparam logic [2:0] S_ALLOC  = 3'd2;
	localparam logic [2:0] S_IDLEP  = 3'd3;
	localparam logic [2:0] S_LRU    = 3'd4;
	localparam logic [2:0] S_SLOT   = 3'd5;
	localparam logic [2:0] S_FINISH = 3'd6;

	logic [2:0] state_q;
	logic [sprc_pkg::SLOT_W-1:0] ptr_q;

	logic [47:0] idle_timeout_q;
	logic [4:0]  max_entries_q;
	logic [3:0]  max_missed_q;

	// per-slot storage
	logic [sprc_pkg::SLOTS-1:0] valid_q;
	logic [31:0] key_q   [sprc_pkg::SLOTS];
	logic [7:0]  refs_q  [sprc_pkg::SLOTS];
	logic [47:0] last_q  [sprc_pkg::SLOTS];
	logic        broken_q[sprc_pkg::SLOTS];
	logic [3:0]  missed_q[sprc_pkg::SLOTS];

	// latched item
	logic [1:0]  op_q;
	logic [31:0] key_in_q;
	logic [3:0]  idx_q;
	logic [47:0] now_q;
	logic        conn_q;
	logic        echo_q;

	// work registers
	logic [2:0]  status_q;
	logic [3:0]  slot_q;
	logic [4:0]  evict_q;
	logic [4:0]  count_q;
	logic        found_q;
	logic [3:0]  best_q;
	logic [47:0] best_time_q;

	logic [48:0] idle_sum;
	logic        reap_hit;
	logic        lru_cand;
	logic        ptr_last;
	logic [4:0]  cnt_after;
	logic        slot_op_end;

	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = !busy;
	assign ptr_last  = (ptr_q == sprc_pkg::slot_t'(sprc_pkg::SLOTS - 1));

	// shared compare unit on the walked slot
	assign idle_sum = {1'b0, last_q[ptr_q]} + {1'b0, idle_timeout_q};
	assign reap_hit = valid_q[ptr_q] && (refs_q[ptr_q] == 8'd0) &&
		(broken_q[ptr_q] || (idle_sum < {1'b0, now_q}));
	assign lru_cand = valid_q[ptr_q] && (refs_q[ptr_q] == 8'd0) &&
		(!found_q || (last_q[ptr_q] < best_time_q));
	assign cnt_after = count_q + ((valid_q[ptr_q] && !reap_hit) ? 5'd1 : 5'd0);

	// slot operations that report the addressed entry's count or removal
	assign slot_op_end = (status_q == sprc_pkg::ST_DONE) ||
		(status_q == sprc_pkg::ST_UNDERFLOW);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_timeout_q <= sprc_pkg::IDLE_TIMEOUT_RST;
			max_entries_q  <= sprc_pkg::MAX_ENTRIES_RST;
			max_missed_q   <= sprc_pkg::MAX_MISSED_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				sprc_pkg::CFG_IDLE_TIMEOUT: idle_timeout_q <= cfg_data;
				sprc_pkg::CFG_MAX_ENTRIES:  max_entries_q  <= cfg_data[4:0];
				sprc_pkg::CFG_MAX_MISSED:   max_missed_q   <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= '0;
			done    <= 1'b0;
			ptr_q   <= '0;
			found_q <= 1'b0;
		end else begin
			done <= (state_q == S_FINISH);
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						ptr_q   <= '0;
						found_q <= 1'b0;
						state_q <= (operation == sprc_pkg::OP_ACQUIRE) ? S_SEARCH : S_SLOT;
					end
				end
				S_SEARCH: begin
					// advance until a live, unbroken key match
					if (valid_q[ptr_q] && !broken_q[ptr_q] && key_q[ptr_q] == key_in_q) begin
						state_q <= S_FINISH;
					end else if (ptr_last) begin
						ptr_q   <= '0;
						state_q <= conn_q ? S_ALLOC : S_FINISH;
					end else begin
						ptr_q <= ptr_q + 1'b1;
					end
				end
				S_ALLOC: begin
					if (!valid_q[ptr_q]) begin
						valid_q[ptr_q] <= 1'b1;
						ptr_q   <= '0;
						state_q <= S_IDLEP;
					end else if (ptr_last) begin
						state_q <= S_FINISH;
					end else begin
						ptr_q <= ptr_q + 1'b1;
					end
				end
				S_IDLEP: begin
					// drop broken or timed-out idle entries, count survivors
					if (reap_hit) valid_q[ptr_q] <= 1'b0;
					ptr_q <= ptr_q + 1'b1;
					if (ptr_last) begin
						found_q <= 1'b0;
						state_q <= (cnt_after > max_entries_q) ? S_LRU : S_FINISH;
					end
				end
				S_LRU: begin
					ptr_q <= ptr_q + 1'b1;
					if (ptr_last) begin
						found_q <= 1'b0;
						if (!(found_q || lru_cand)) begin
							state_q <= S_FINISH;
						end else begin
							valid_q[lru_cand ? ptr_q : best_q] <= 1'b0;
							if ((count_q - 5'd1) <= max_entries_q) state_q <= S_FINISH;
						end
					end else if (lru_cand) begin
						found_q <= 1'b1;
					end
				end
				S_SLOT: begin
					if (valid_q[idx_q] && op_q == sprc_pkg::OP_RELEASE &&
						refs_q[idx_q] <= 8'd1) begin
						ptr_q   <= '0;
						state_q <= S_IDLEP;
					end else begin
						state_q <= S_FINISH;
					end
					if (valid_q[idx_q]) begin
						if (op_q == sprc_pkg::OP_INVALIDATE) begin
							if (refs_q[idx_q] == 8'd0) valid_q[idx_q] <= 1'b0;
						end else if (op_q == sprc_pkg::OP_KEEPALIVE && refs_q[idx_q] == 8'd0) begin
							if (broken_q[idx_q] || missed_q[idx_q] > max_missed_q ||
								(!echo_q && ((missed_q[idx_q] == 4'd15 ? 4'd15 :
								missed_q[idx_q] + 4'd1) > max_missed_q)))
								valid_q[idx_q] <= 1'b0;
						end
					end
				end
				S_FINISH: begin
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload: item latch, entry fields, work registers and outputs
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				op_q     <= operation;
				key_in_q <= lookup_key;
				idx_q    <= slot_index;
				now_q    <= now_time;
				conn_q   <= connect_ok;
				echo_q   <= echo_ok;
				evict_q  <= '0;
				slot_q   <= (operation == sprc_pkg::OP_ACQUIRE) ? 4'd0 : slot_index;
				status_q <= (operation == sprc_pkg::OP_ACQUIRE) ? sprc_pkg::ST_CONN_FAIL
					: sprc_pkg::ST_DONE;
			end
			S_SEARCH: begin
				if (valid_q[ptr_q] && !broken_q[ptr_q] && key_q[ptr_q] == key_in_q) begin
					if (refs_q[ptr_q] != 8'hFF) refs_q[ptr_q] <= refs_q[ptr_q] + 8'd1;
					last_q[ptr_q] <= now_q;
					status_q <= sprc_pkg::ST_REUSED;
					slot_q   <= ptr_q;
				end else if (ptr_last && conn_q) begin
					status_q <= sprc_pkg::ST_FULL;
				end
				count_q <= '0;
			end
			S_ALLOC: begin
				if (!valid_q[ptr_q]) begin
					key_q[ptr_q]    <= key_in_q;
					refs_q[ptr_q]   <= 8'd1;
					last_q[ptr_q]   <= now_q;
					broken_q[ptr_q] <= 1'b0;
					missed_q[ptr_q] <= '0;
					slot_q   <= ptr_q;
					status_q <= sprc_pkg::ST_CREATED;
				end
				count_q <= '0;
			end
			S_IDLEP: begin
				if (reap_hit) evict_q <= evict_q + 5'd1;
				count_q <= cnt_after;
			end
			S_LRU: begin
				if (lru_cand) begin
					best_q      <= ptr_q;
					best_time_q <= last_q[ptr_q];
				end
				if (ptr_last && (found_q || lru_cand)) begin
					evict_q <= evict_q + 5'd1;
					count_q <= count_q - 5'd1;
				end
			end
			S_SLOT: begin
				count_q <= '0;
				if (!valid_q[idx_q]) begin
					status_q <= sprc_pkg::ST_NOT_LIVE;
				end else if (op_q == sprc_pkg::OP_RELEASE) begin
					if (refs_q[idx_q] == 8'd0) status_q <= sprc_pkg::ST_UNDERFLOW;
					else refs_q[idx_q] <= refs_q[idx_q] - 8'd1;
					last_q[idx_q] <= now_q;
				end else if (op_q == sprc_pkg::OP_INVALIDATE) begin
					broken_q[idx_q] <= 1'b1;
				end else if (refs_q[idx_q] == 8'd0 && !broken_q[idx_q]) begin
					if (missed_q[idx_q] > max_missed_q) begin
						broken_q[idx_q] <= 1'b1;
					end else if (echo_q) begin
						missed_q[idx_q] <= '0;
					end else if (missed_q[idx_q] != 4'd15) begin
						missed_q[idx_q] <= missed_q[idx_q] + 4'd1;
					end
				end
			end
			S_FINISH: begin
				status        <= status_q;
				result_slot   <= slot_q;
				evicted_count <= evict_q;
				// failed or full acquires and dead slots report no count
				entry_removed <= slot_op_end && !valid_q[slot_q];
				if (status_q == sprc_pkg::ST_REUSED || status_q == sprc_pkg::ST_CREATED ||
					(slot_op_end && valid_q[slot_q])) begin
					ref_count <= refs_q[slot_q];
				end else begin
					ref_count <= 8'd0;
				end
			end
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while busy");
	a_done_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q) == S_FINISH)
		else $error("result without finish step");
	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready |-> state_q == S_IDLE)
		else $error("config accepted while working");
`endif

endmodule
`default_nettype wire
